// ----- src/hdg_pd_pkg.sv -----
// Package for the heading PD servo controller.
// Widths, register indexes, reset values and the configuration struct.
// Used by the interfaces, hdg_pd_csr and heading_pd_servo_control_top.
package hdg_pd_pkg;

   localparam int HEAD_W     = 16;
   localparam int ERR_W      = 17;
   localparam int WRAP_W     = 18;
   localparam int DIFF_W     = 18;
   localparam int GAIN_W     = 16;
   localparam int DUTY_W     = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
   localparam int PROD_D_W   = GAIN_W + 1 + DIFF_W;
   localparam int SUM_W      = PROD_D_W + 1;
   localparam int MAG_W      = 27;
   localparam int RECIP_W    = 28;
   localparam int RECIP_SH   = 34;
   localparam int QUOT_W     = MAG_W + RECIP_W - RECIP_SH;
   localparam int QS_W       = QUOT_W + 1;
   localparam int DUTY_X_W   = 24;

   // divide by 25600: drop 8 bits, then multiply by ceil(2^34 / 100)
   localparam int                 PRE_SHIFT = 8;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(171798692);

   localparam logic signed [WRAP_W-1:0] HALF_TURN = WRAP_W'(18000);
   localparam logic signed [WRAP_W-1:0] FULL_TURN = WRAP_W'(36000);

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_CENTER = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_MIN    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_MAX    = CSR_IDX_W'(4);

   localparam logic [GAIN_W-1:0] RST_GAIN_P      = GAIN_W'(896);
   localparam logic [GAIN_W-1:0] RST_GAIN_D      = GAIN_W'(10240);
   localparam logic [DUTY_W-1:0] RST_DUTY_CENTER = DUTY_W'(740);
   localparam logic [DUTY_W-1:0] RST_DUTY_MIN    = DUTY_W'(520);
   localparam logic [DUTY_W-1:0] RST_DUTY_MAX    = DUTY_W'(1020);

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_d;
      logic [DUTY_W-1:0] duty_center;
      logic [DUTY_W-1:0] duty_min;
      logic [DUTY_W-1:0] duty_max;
   } cfg_type;

endpackage

// ----- src/hdg_pd_ifs.sv -----
// Handshake interfaces of the heading PD servo controller: request, response
// and register write channels. Depends on hdg_pd_pkg.
interface hdg_pd_req_if import hdg_pd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [HEAD_W-1:0] heading_now;
   logic signed [HEAD_W-1:0] heading_target;

   modport source (output valid, heading_now, heading_target, input ready);
   modport sink   (input valid, heading_now, heading_target, output ready);
endinterface

interface hdg_pd_rsp_if import hdg_pd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [DUTY_W-1:0]       duty;
   logic signed [ERR_W-1:0] heading_error;

   modport source (output valid, duty, heading_error, input ready);
   modport sink   (input valid, duty, heading_error, output ready);
endinterface

interface hdg_pd_csr_if import hdg_pd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// ----- src/hdg_pd_csr.sv -----
// Configuration registers of the heading PD servo controller.
// Depends on hdg_pd_pkg and hdg_pd_csr_if.
module hdg_pd_csr import hdg_pd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   hdg_pd_csr_if.sink   csr_bus,
   output cfg_type      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            REG_GAIN_P:      cfg_in.gain_p      = csr_bus.write_data;
            REG_GAIN_D:      cfg_in.gain_d      = csr_bus.write_data;
            REG_DUTY_CENTER: cfg_in.duty_center = csr_bus.write_data[DUTY_W-1:0];
            REG_DUTY_MIN:    cfg_in.duty_min    = csr_bus.write_data[DUTY_W-1:0];
            REG_DUTY_MAX:    cfg_in.duty_max    = csr_bus.write_data[DUTY_W-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p      <= RST_GAIN_P;
         cfg_ff.gain_d      <= RST_GAIN_D;
         cfg_ff.duty_center <= RST_DUTY_CENTER;
         cfg_ff.duty_min    <= RST_DUTY_MIN;
         cfg_ff.duty_max    <= RST_DUTY_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/heading_pd_servo_control_top.sv -----
// Heading PD servo controller: wrapped heading error, PD term, clamped duty.
// Depends on hdg_pd_pkg, hdg_pd_ifs (interfaces) and hdg_pd_csr.
//
//  channel   | direction | word
//  req_bus   | in        | heading_now, heading_target
//  rsp_bus   | out       | duty, heading_error
//  csr_bus   | in        | reg_index, write_data (always ready)
//
// One word accepted per cycle while req_bus is ready. A response passes through
// the five-register pipeline (error, products, magnitude, quotient, output).
// Each stage holds while the next is full and stalled, so an unserved
// response back-pressures req_bus only once the pipeline fills.
// Reset empties the pipeline, clears the previous error and loads default gains.
module heading_pd_servo_control_top import hdg_pd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   hdg_pd_req_if.sink    req_bus,
   hdg_pd_rsp_if.source  rsp_bus,
   hdg_pd_csr_if.sink    csr_bus
);

   cfg_type cfg;

   hdg_pd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // stage valids and advance
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, out_v_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy_out;
   logic accept;

   assign rdy_out       = !out_v_ff || rsp_bus.ready;
   assign rdy4          = !s4_v_ff || rdy_out;
   assign rdy3          = !s3_v_ff || rdy4;
   assign rdy2          = !s2_v_ff || rdy3;
   assign rdy1          = !s1_v_ff || rdy2;
   assign req_bus.ready = rdy1;
   assign accept        = req_bus.valid && rdy1;

   // error wrap on the incoming word
   logic signed [WRAP_W-1:0] now_x, tgt_x, err_wide;
   logic signed [ERR_W-1:0]  err_in;
   logic signed [DIFF_W-1:0] diff_in;
   logic signed [ERR_W-1:0]  prev_err_ff;

   always_comb begin
      now_x = WRAP_W'(req_bus.heading_now);
      tgt_x = WRAP_W'(req_bus.heading_target);
      if (now_x > 0 && tgt_x <= now_x - HALF_TURN && tgt_x > -HALF_TURN) begin
         err_wide = FULL_TURN - now_x + tgt_x;
      end else if (now_x < 0 && tgt_x >= HALF_TURN + now_x && tgt_x < HALF_TURN) begin
         err_wide = tgt_x - now_x - FULL_TURN;
      end else begin
         err_wide = tgt_x - now_x;
      end
      err_in  = err_wide[ERR_W-1:0];
      diff_in = DIFF_W'(err_in) - DIFF_W'(prev_err_ff);
   end

   // stage 1: error and derivative
   logic signed [ERR_W-1:0]  s1_err_ff;
   logic signed [DIFF_W-1:0] s1_diff_ff;

   // stage 2: products
   logic signed [PROD_P_W-1:0] prod_p_in, s2_prod_p_ff;
   logic signed [PROD_D_W-1:0] prod_d_in, s2_prod_d_ff;
   logic signed [ERR_W-1:0]    s2_err_ff;

   assign prod_p_in = PROD_P_W'($signed({1'b0, cfg.gain_p})) * PROD_P_W'(s1_err_ff);
   assign prod_d_in = PROD_D_W'($signed({1'b0, cfg.gain_d})) * PROD_D_W'(s1_diff_ff);

   // stage 3: sign and magnitude of the sum, divided by 256
   logic signed [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0]        abs_in;
   logic [MAG_W-1:0]        mag_in, s3_mag_ff;
   logic                    s3_neg_ff;
   logic signed [ERR_W-1:0] s3_err_ff;

   always_comb begin
      sum_in = SUM_W'(s2_prod_p_ff) + SUM_W'(s2_prod_d_ff);
      abs_in = sum_in[SUM_W-1] ? (~sum_in + SUM_W'(1)) : sum_in;
      mag_in = abs_in[PRE_SHIFT +: MAG_W];
   end

   // stage 4: divide by 100 through the reciprocal
   logic [MAG_W+RECIP_W-1:0] recip_prod;
   logic [QUOT_W-1:0]        s4_quot_ff;
   logic                     s4_neg_ff;
   logic signed [ERR_W-1:0]  s4_err_ff;

   assign recip_prod = (MAG_W+RECIP_W)'(s3_mag_ff) * (MAG_W+RECIP_W)'(RECIP_100);

   // output: centre minus PD term, clamp to max then min
   logic signed [QS_W-1:0]     quot_s;
   logic signed [DUTY_X_W-1:0] duty_raw, duty_hi, duty_lo;
   logic signed [DUTY_X_W-1:0] max_x, min_x;
   logic [DUTY_W-1:0]          duty_in, duty_ff;
   logic signed [ERR_W-1:0]    out_err_ff;

   always_comb begin
      quot_s   = s4_neg_ff ? -$signed({1'b0, s4_quot_ff}) : $signed({1'b0, s4_quot_ff});
      max_x    = $signed({{(DUTY_X_W-DUTY_W){1'b0}}, cfg.duty_max});
      min_x    = $signed({{(DUTY_X_W-DUTY_W){1'b0}}, cfg.duty_min});
      duty_raw = $signed({{(DUTY_X_W-DUTY_W){1'b0}}, cfg.duty_center}) - DUTY_X_W'(quot_s);
      duty_hi  = (duty_raw >= max_x) ? max_x : duty_raw;
      duty_lo  = (duty_hi <= min_x) ? min_x : duty_hi;
      duty_in  = duty_lo[DUTY_W-1:0];
   end

   assign rsp_bus.valid         = out_v_ff;
   assign rsp_bus.duty          = duty_ff;
   assign rsp_bus.heading_error = out_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         s4_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
         prev_err_ff <= '0;
      end else begin
         if (rdy1)    s1_v_ff  <= req_bus.valid;
         if (rdy2)    s2_v_ff  <= s1_v_ff;
         if (rdy3)    s3_v_ff  <= s2_v_ff;
         if (rdy4)    s4_v_ff  <= s3_v_ff;
         if (rdy_out) out_v_ff <= s4_v_ff;
         if (accept)  prev_err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_err_ff  <= err_in;
         s1_diff_ff <= diff_in;
      end
      if (rdy2) begin
         s2_prod_p_ff <= prod_p_in;
         s2_prod_d_ff <= prod_d_in;
         s2_err_ff    <= s1_err_ff;
      end
      if (rdy3) begin
         s3_mag_ff <= mag_in;
         s3_neg_ff <= sum_in[SUM_W-1];
         s3_err_ff <= s2_err_ff;
      end
      if (rdy4) begin
         s4_quot_ff <= recip_prod[RECIP_SH +: QUOT_W];
         s4_neg_ff  <= s3_neg_ff;
         s4_err_ff  <= s3_err_ff;
      end
      if (rdy_out) begin
         duty_ff    <= duty_in;
         out_err_ff <= s4_err_ff;
      end
   end

endmodule

// ----- test/servo_duty_checker.sv -----
`timescale 1ns / 1ps
// Checker for heading_pd_servo_control_top: follows register writes, predicts the
// duty word for every heading word and compares it with the response channel.
// Depends on hdg_pd_pkg and the channel interfaces in hdg_pd_ifs.
module servo_duty_checker import hdg_pd_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   hdg_pd_req_if req_mon,
   hdg_pd_rsp_if rsp_mon,
   hdg_pd_csr_if csr_mon,
   output int    mismatches,
   output int    words_due
);

   localparam longint HALF_CDEG  = 18000;
   localparam longint FULL_CDEG  = 36000;
   localparam longint GAIN_SCALE = 25600;

   typedef struct packed {
      logic [DUTY_W-1:0]       duty;
      logic signed [ERR_W-1:0] heading_error;
   } servo_word_type;

   cfg_type        servo_cfg;
   longint         last_error;
   servo_word_type duty_due_q[$];
   int             fail_count;

   function automatic servo_word_type next_servo_word(input logic signed [HEAD_W-1:0] now_in,
                                                      input logic signed [HEAD_W-1:0] tgt_in);
      longint         now_cd;
      longint         tgt_cd;
      longint         err;
      longint         pd;
      longint         duty;
      servo_word_type w;
      now_cd = now_in;
      tgt_cd = tgt_in;
      if (now_cd > 0 && tgt_cd <= now_cd - HALF_CDEG && tgt_cd > -HALF_CDEG)
         err = FULL_CDEG - now_cd + tgt_cd;
      else if (now_cd < 0 && tgt_cd >= now_cd + HALF_CDEG && tgt_cd < HALF_CDEG)
         err = tgt_cd - now_cd - FULL_CDEG;
      else
         err = tgt_cd - now_cd;
      pd = (longint'(servo_cfg.gain_p) * err
            + longint'(servo_cfg.gain_d) * (err - last_error)) / GAIN_SCALE;
      last_error = err;
      duty = longint'(servo_cfg.duty_center) - pd;
      if (duty >= longint'(servo_cfg.duty_max))
         duty = longint'(servo_cfg.duty_max);
      if (duty <= longint'(servo_cfg.duty_min))
         duty = longint'(servo_cfg.duty_min);
      w.duty          = DUTY_W'(duty);
      w.heading_error = ERR_W'(err);
      return w;
   endfunction

   always @(posedge clock) begin
      servo_word_type got;
      servo_word_type want;
      if (reset) begin
         servo_cfg = '{gain_p: RST_GAIN_P, gain_d: RST_GAIN_D, duty_center: RST_DUTY_CENTER,
                       duty_min: RST_DUTY_MIN, duty_max: RST_DUTY_MAX};
         last_error = 0;
         duty_due_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.duty          = rsp_mon.duty;
            got.heading_error = rsp_mon.heading_error;
            if (duty_due_q.size() == 0) begin
               $error("duty word with none due: duty %0d, heading_error %0d",
                      got.duty, got.heading_error);
               fail_count++;
            end else begin
               want = duty_due_q.pop_front();
               if (got.duty !== want.duty) begin
                  $error("duty: expected %0d, actual %0d", want.duty, got.duty);
                  fail_count++;
               end
               if (got.heading_error !== want.heading_error) begin
                  $error("heading_error: expected %0d, actual %0d",
                         want.heading_error, got.heading_error);
                  fail_count++;
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.reg_index)
               REG_GAIN_P:      servo_cfg.gain_p      = csr_mon.write_data;
               REG_GAIN_D:      servo_cfg.gain_d      = csr_mon.write_data;
               REG_DUTY_CENTER: servo_cfg.duty_center = csr_mon.write_data[DUTY_W-1:0];
               REG_DUTY_MIN:    servo_cfg.duty_min    = csr_mon.write_data[DUTY_W-1:0];
               REG_DUTY_MAX:    servo_cfg.duty_max    = csr_mon.write_data[DUTY_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            duty_due_q.push_back(next_servo_word(req_mon.heading_now, req_mon.heading_target));
      end
      mismatches <= fail_count;
      words_due  <= duty_due_q.size();
   end

endmodule

// ----- test/tb_heading_pd_servo_control_top.sv -----
`timescale 1ns / 1ps
// Testbench top for heading_pd_servo_control_top: resets the block, drives heading
// words with random gaps and register writes, and gives the verdict.
// Depends on hdg_pd_pkg, hdg_pd_ifs, servo_duty_checker and the block's RTL.
module tb_heading_pd_servo_control_top;
   import hdg_pd_pkg::*;

   localparam int IDLE_LIMIT      = 2000;
   localparam int SQUEEZE_CYCLES  = 120;
   localparam int SETTLE_CYCLES   = 12;
   localparam int REG_SPARE_FIRST = REG_DUTY_MAX + 1;
   localparam int REG_SLOTS       = 1 << CSR_IDX_W;

   logic clock = 1'b0;
   logic reset;
   bit   calm = 1'b0;
   bit   squeeze_due = 1'b0;
   int   mismatches;
   int   words_due;
   int   idle_cycles = 0;

   hdg_pd_req_if req_bus ();
   hdg_pd_rsp_if rsp_bus ();
   hdg_pd_csr_if csr_bus ();

   heading_pd_servo_control_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   servo_duty_checker duty_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .mismatches (mismatches),
      .words_due  (words_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int rim_heading();
      case ($urandom_range(6))
         0:       return 18000;
         1:       return -18000;
         2:       return 0;
         3:       return 1;
         4:       return -1;
         5:       return 17999;
         default: return -17999;
      endcase
   endfunction

   function automatic cfg_type random_servo_cfg();
      cfg_type c;
      c.gain_p      = ($urandom_range(3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(2048));
      c.gain_d      = ($urandom_range(3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(8192));
      c.duty_center = DUTY_W'($urandom_range(10000));
      c.duty_min    = DUTY_W'($urandom_range(5000));
      c.duty_max    = DUTY_W'($urandom_range(10000, 5000));
      if ($urandom_range(4) == 0) begin
         c.duty_min = DUTY_W'($urandom);
         c.duty_max = DUTY_W'($urandom);
      end
      return c;
   endfunction

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= idx;
      csr_bus.write_data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   task automatic load_servo_cfg(input cfg_type c, input bit poke_spare);
      if (poke_spare)
         for (int i = REG_SPARE_FIRST; i < REG_SLOTS; i++)
            put_reg(CSR_IDX_W'(i), CSR_DATA_W'($urandom));
      put_reg(REG_GAIN_P, c.gain_p);
      put_reg(REG_GAIN_D, c.gain_d);
      put_reg(REG_DUTY_CENTER, {2'($urandom), c.duty_center});
      put_reg(REG_DUTY_MIN, {2'($urandom), c.duty_min});
      put_reg(REG_DUTY_MAX, {2'($urandom), c.duty_max});
      csr_bus.valid <= 1'b0;
   endtask

   task automatic offer_heading(input logic signed [HEAD_W-1:0] now_h,
                                input logic signed [HEAD_W-1:0] tgt_h);
      req_bus.valid          <= 1'b1;
      req_bus.heading_now    <= now_h;
      req_bus.heading_target <= tgt_h;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (!calm && $urandom_range(4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(15, 1)) @(posedge clock);
      end
   endtask

   task automatic run_headings(input int count);
      int n;
      int t;
      repeat (count) begin
         n = int'($urandom_range(36000)) - 18000;
         case ($urandom_range(19))
            0, 1:             begin n = $urandom; t = $urandom; end
            2, 3, 4:          t = n + ($urandom_range(1) ? 18000 : -18000)
                                  + int'($urandom_range(6)) - 3;
            5, 6:             begin n = rim_heading(); t = rim_heading(); end
            7, 8, 9, 10, 11:  t = n + int'($urandom_range(400)) - 200;
            default:          t = int'($urandom_range(36000)) - 18000;
         endcase
         offer_heading(HEAD_W'(n), HEAD_W'(t));
      end
   endtask

   task automatic drain_words();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
   endtask

   initial begin : rsp_pacing
      forever begin
         if (squeeze_due) begin
            squeeze_due = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(60, 1)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.heading_now    <= '0;
      req_bus.heading_target <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.reg_index      <= '0;
      csr_bus.write_data     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // seam of the wrap, the limits and the raw 16-bit extremes
      offer_heading(0, 0);
      offer_heading(18000, 18000);
      offer_heading(-18000, -18000);
      offer_heading(18000, -18000);
      offer_heading(-18000, 18000);
      offer_heading(10000, -9000);
      offer_heading(-10000, 9000);
      offer_heading(18000, 0);
      offer_heading(1, -17999);
      offer_heading(1, -18000);
      offer_heading(-1, 17999);
      offer_heading(-1, 18000);
      offer_heading(-18000, 0);
      offer_heading(0, 18000);
      offer_heading(0, -18000);
      offer_heading(9000, -9000);
      offer_heading(-9000, 9000);
      offer_heading(32767, -32768);
      offer_heading(-32768, 32767);
      offer_heading(32767, 0);
      offer_heading(-32768, 0);
      offer_heading(-1, -1);

      squeeze_due = 1'b1;
      run_headings(150);
      drain_words();

      load_servo_cfg('{gain_p: '1, gain_d: '1, duty_center: '1, duty_min: '0, duty_max: '1}, 1'b1);
      run_headings(120);
      drain_words();

      load_servo_cfg('{gain_p: '0, gain_d: '0, duty_center: 10000, duty_min: 0,
                       duty_max: 10000}, 1'b0);
      run_headings(80);
      drain_words();

      // crossed limits: the lower limit, duty_min, wins
      load_servo_cfg('{gain_p: RST_GAIN_P, gain_d: RST_GAIN_D, duty_center: 5000,
                       duty_min: 9000, duty_max: 1000}, 1'b0);
      run_headings(80);
      drain_words();

      load_servo_cfg('{gain_p: RST_GAIN_P, gain_d: RST_GAIN_D, duty_center: 0,
                       duty_min: 0, duty_max: 0}, 1'b1);
      run_headings(60);
      drain_words();

      repeat (4) begin
         load_servo_cfg(random_servo_cfg(), 1'b1);
         run_headings(100);
         drain_words();
      end

      calm = 1'b1;
      load_servo_cfg('{gain_p: RST_GAIN_P, gain_d: RST_GAIN_D, duty_center: RST_DUTY_CENTER,
                       duty_min: RST_DUTY_MIN, duty_max: RST_DUTY_MAX}, 1'b0);
      run_headings(140);
      drain_words();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && words_due == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
